FILE: design/rgb_hsi_red_pixel_classifier_defines.svh
// Assertion macros used by the top-level RTL file.
`ifndef RGB_HSI_RED_PIXEL_CLASSIFIER_DEFINES_SVH
`define RGB_HSI_RED_PIXEL_CLASSIFIER_DEFINES_SVH

// same-cycle implication
`define RHSI_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHSI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rhsi_pkg.sv
`default_nettype none
package rhsi_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] int_pct;
        logic       is_target;
    } hsi_t;

    typedef enum logic [2:0] {
        REG_HUE_LOW  = 3'd0,
        REG_HUE_HIGH = 3'd1,
        REG_SAT_LOW  = 3'd2,
        REG_SAT_HIGH = 3'd3,
        REG_INT_LOW  = 3'd4,
        REG_INT_HIGH = 3'd5
    } cfg_reg_t;

    localparam logic [8:0] HUE_LOW_RST  = 9'd312;
    localparam logic [8:0] HUE_HIGH_RST = 9'd360;
    localparam logic [6:0] SAT_LOW_RST  = 7'd17;
    localparam logic [6:0] SAT_HIGH_RST = 7'd100;
    localparam logic [6:0] INT_LOW_RST  = 7'd18;
    localparam logic [6:0] INT_HIGH_RST = 7'd100;

    // sign ranks, ordered so that a numeric compare orders the signs
    localparam logic [1:0] RANK_NEG  = 2'd0;
    localparam logic [1:0] RANK_ZERO = 2'd1;
    localparam logic [1:0] RANK_POS  = 2'd2;

    localparam int SEARCH_STEPS = 8;
    localparam int DIV_STEPS    = 7;
    localparam logic [9:0] INT_DIVISOR = 10'd765;

    localparam logic [63:0] COS1_Q30 = 64'd1073578288;
    localparam logic [63:0] SIN1_Q30 = 64'd18739379;

    typedef struct packed {
        logic signed [9:0] n_val;
        logic [17:0]       n_sq;
        logic [15:0]       d_val;
        logic              bg_le;
        logic              grey;
        logic              active;
        logic [7:0]        t_val;
        logic [7:0]        cand;
        logic [1:0]        c_rank;
        logic [59:0]       prod;
        logic [9:0]        sum_val;
        logic [16:0]       sat_rem;
        logic [6:0]        sat_q;
        logic [16:0]       int_rem;
        logic [6:0]        int_q;
        logic [8:0]        hue;
    } work_t;

    // cos(k deg) in Q22, k = 0..90, by repeated one-degree rotation in Q30
    function automatic logic [90:0][22:0] cos_rom_build();
        logic [63:0]       a;
        logic [63:0]       s;
        logic [63:0]       na;
        logic [63:0]       ns;
        logic [90:0][22:0] rom;
        a   = 64'd1 << 30;
        s   = '0;
        rom = '0;
        rom[0] = 23'd4194304;
        for (int k = 1; k < 90; k++) begin
            na = (a * COS1_Q30 - s * SIN1_Q30 + (64'd1 << 29)) >> 30;
            ns = (s * COS1_Q30 + a * SIN1_Q30 + (64'd1 << 29)) >> 30;
            a = na;
            s = ns;
            rom[k] = 23'((a + 64'd128) >> 8);
        end
        rom[60] = 23'd2097152;
        rom[90] = '0;
        return rom;
    endfunction

    function automatic logic [90:0][44:0] cos_sq_build();
        logic [90:0][22:0] c;
        logic [90:0][44:0] sq;
        c  = cos_rom_build();
        sq = '0;
        for (int k = 0; k <= 90; k++) begin
            sq[k] = 45'(c[k]) * 45'(c[k]);
        end
        return sq;
    endfunction

    localparam logic [90:0][44:0] COS_SQ = cos_sq_build();

endpackage
`default_nettype wire

FILE: design/rhsi_step.sv
`default_nettype none
module rhsi_step #(
    parameter int STEP = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire rhsi_pkg::work_t in_work,
    output logic                 out_valid,
    output rhsi_pkg::work_t      out_work
);
    import rhsi_pkg::*;

    localparam bit IS_LAST = (STEP >= SEARCH_STEPS);
    localparam bit HAS_DIV = (STEP < DIV_STEPS);
    localparam int SH      = HAS_DIV ? (DIV_STEPS - 1 - STEP) : 0;
    localparam logic [7:0] CAND_BIT = IS_LAST ? 8'd0 : 8'(1 << (SEARCH_STEPS - 1 - STEP));

    work_t      mid_next, mid_reg, fin_next, fin_reg;
    logic       mid_valid_reg, fin_valid_reg;
    logic [6:0] idx;
    logic [60:0] full_prod;
    logic [59:0] lhs;
    logic [1:0]  sn;
    logic        le, eq;
    logic [16:0] sat_dv, int_dv;

    // lookup and multiply
    always_comb begin
        mid_next = in_work;
        mid_next.cand = IS_LAST ? in_work.t_val : (in_work.t_val | CAND_BIT);
        if (mid_next.cand <= 8'd90) begin
            idx = mid_next.cand[6:0];
        end else if (mid_next.cand <= 8'd180) begin
            idx = 7'(8'd180 - mid_next.cand);
        end else begin
            idx = '0;
        end
        full_prod = 61'(COS_SQ[idx]) * 61'(in_work.d_val);
        mid_next.prod = full_prod[59:0];
        if (COS_SQ[idx] == '0) begin
            mid_next.c_rank = RANK_ZERO;
        end else if (mid_next.cand > 8'd90) begin
            mid_next.c_rank = RANK_NEG;
        end else begin
            mid_next.c_rank = RANK_POS;
        end
    end

    // compare and update
    always_comb begin
        fin_next = mid_reg;
        lhs = {mid_reg.n_sq, 42'd0};
        if (mid_reg.n_val > 0) begin
            sn = RANK_POS;
        end else if (mid_reg.n_val < 0) begin
            sn = RANK_NEG;
        end else begin
            sn = RANK_ZERO;
        end
        if (sn != mid_reg.c_rank) begin
            le = (sn < mid_reg.c_rank);
            eq = 1'b0;
        end else if (sn == RANK_ZERO) begin
            le = 1'b1;
            eq = 1'b1;
        end else if (sn == RANK_POS) begin
            le = (lhs <= mid_reg.prod);
            eq = (lhs == mid_reg.prod);
        end else begin
            le = (lhs >= mid_reg.prod);
            eq = (lhs == mid_reg.prod);
        end
        if (IS_LAST) begin
            if (!mid_reg.active) begin
                fin_next.hue = '0;
            end else if (mid_reg.bg_le) begin
                fin_next.hue = {1'b0, mid_reg.t_val};
            end else if (eq) begin
                fin_next.hue = 9'd360 - {1'b0, mid_reg.t_val};
            end else begin
                fin_next.hue = 9'd359 - {1'b0, mid_reg.t_val};
            end
        end else if (mid_reg.cand <= 8'd180 && le) begin
            fin_next.t_val = mid_reg.cand;
        end
        sat_dv = 17'(mid_reg.sum_val) << SH;
        int_dv = 17'(INT_DIVISOR) << SH;
        if (HAS_DIV) begin
            if (mid_reg.sat_rem >= sat_dv) begin
                fin_next.sat_rem   = mid_reg.sat_rem - sat_dv;
                fin_next.sat_q[SH] = 1'b1;
            end
            if (mid_reg.int_rem >= int_dv) begin
                fin_next.int_rem   = mid_reg.int_rem - int_dv;
                fin_next.int_q[SH] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            mid_valid_reg <= in_valid;
            fin_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_reg <= mid_next;
            fin_reg <= fin_next;
        end
    end

    assign out_valid = fin_valid_reg;
    assign out_work  = fin_reg;

endmodule
`default_nettype wire

FILE: design/rgb_hsi_red_pixel_classifier.sv
// RGB to HSI pixel classifier with a configurable color window.
// Input: one RGB pixel word per s_valid/s_ready handshake. Output: one word
// per pixel on m_valid/m_ready with hue (degrees), saturation and intensity
// (percent) and a flag set when all three fall inside the window.
// Window bounds are written on the cfg_* channel (index 0..5: hue low/high,
// sat low/high, int low/high); cfg_ready is always high, unknown indexes
// are dropped. Write them only while no pixel is in flight.
// Throughput: one pixel per clock while not stalled. The hue is found by
// an 8-step bit-wise search over a squared-cosine ROM plus one exact-match
// step; each step is a multiply stage and a compare stage. Saturation and
// intensity divisions run as restoring steps alongside the first seven
// search steps. Stall: the whole pipeline holds while the output word
// waits; s_ready drops only then. Reset: synchronous, active low; clears
// the pipeline valid bits and reloads the default red window
// (hue 312..360, sat 17..100, int 18..100); intensity bounds are exclusive.
`default_nettype none
`include "rgb_hsi_red_pixel_classifier_defines.svh"
module rgb_hsi_red_pixel_classifier (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire rhsi_pkg::pixel_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output rhsi_pkg::hsi_t      m_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [8:0]     cfg_data
);
    import rhsi_pkg::*;

    localparam int NSTEP = SEARCH_STEPS + 1;

    logic       en;
    logic [8:0] hue_low_reg, hue_high_reg;
    logic [6:0] sat_low_reg, sat_high_reg, int_low_reg, int_high_reg;

    pixel_t px_reg;
    logic   px_valid_reg;
    work_t  prep_next, prep_reg;
    logic   prep_valid_reg;
    hsi_t   out_next, out_reg;
    logic   out_valid_reg;

    work_t  chain_work  [0:NSTEP];
    logic   chain_valid [0:NSTEP];

    logic [9:0] sum_w, mn, mx, num;
    logic signed [10:0] rs, gs, bs;
    logic signed [10:0] n_w, dg, db, gb;
    logic signed [21:0] d_w;
    logic signed [21:0] nsq_w;
    logic [16:0] hnum;

    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hue_low_reg  <= HUE_LOW_RST;
            hue_high_reg <= HUE_HIGH_RST;
            sat_low_reg  <= SAT_LOW_RST;
            sat_high_reg <= SAT_HIGH_RST;
            int_low_reg  <= INT_LOW_RST;
            int_high_reg <= INT_HIGH_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HUE_LOW:  hue_low_reg  <= cfg_data;
                REG_HUE_HIGH: hue_high_reg <= cfg_data;
                REG_SAT_LOW:  sat_low_reg  <= cfg_data[6:0];
                REG_SAT_HIGH: sat_high_reg <= cfg_data[6:0];
                REG_INT_LOW:  int_low_reg  <= cfg_data[6:0];
                REG_INT_HIGH: int_high_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // front end: sums, extremes, arccos numerator and radicand
    always_comb begin
        rs    = signed'({3'b000, px_reg.red});
        gs    = signed'({3'b000, px_reg.green});
        bs    = signed'({3'b000, px_reg.blue});
        sum_w = 10'(px_reg.red) + 10'(px_reg.green) + 10'(px_reg.blue);
        mn    = 10'(px_reg.red);
        mx    = 10'(px_reg.red);
        if (10'(px_reg.green) < mn) mn = 10'(px_reg.green);
        if (10'(px_reg.green) > mx) mx = 10'(px_reg.green);
        if (10'(px_reg.blue) < mn)  mn = 10'(px_reg.blue);
        if (10'(px_reg.blue) > mx)  mx = 10'(px_reg.blue);
        num   = sum_w - 10'(3 * mn);
        hnum  = 17'(num) * 17'd100;
        n_w   = 11'(2 * rs - gs - bs);
        dg    = rs - gs;
        db    = rs - bs;
        gb    = gs - bs;
        d_w   = 22'(dg * dg) + 22'(db * gb);
        nsq_w = 22'(n_w * n_w);

        prep_next          = '0;
        prep_next.n_val    = n_w[9:0];
        prep_next.n_sq     = nsq_w[17:0];
        prep_next.d_val    = d_w[15:0];
        prep_next.bg_le    = (px_reg.blue <= px_reg.green);
        prep_next.grey     = (mx == mn);
        prep_next.active   = (mx != mn) && (hnum > 17'(sum_w));
        prep_next.sum_val  = sum_w;
        prep_next.sat_rem  = hnum;
        prep_next.int_rem  = 17'(sum_w) * 17'd100;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_valid_reg   <= 1'b0;
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            px_valid_reg   <= s_valid;
            prep_valid_reg <= px_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= s_data;
            prep_reg <= prep_next;
        end
    end

    assign chain_work[0]  = prep_reg;
    assign chain_valid[0] = prep_valid_reg;

    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        rhsi_step #(
            .STEP(j)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (chain_valid[j]),
            .in_work  (chain_work[j]),
            .out_valid(chain_valid[j+1]),
            .out_work (chain_work[j+1])
        );
    end

    always_comb begin
        out_next.hue_deg = chain_work[NSTEP].hue;
        out_next.sat_pct = chain_work[NSTEP].grey ? 7'd0 : chain_work[NSTEP].sat_q;
        out_next.int_pct = chain_work[NSTEP].int_q;
        out_next.is_target =
            (out_next.hue_deg >= hue_low_reg) && (out_next.hue_deg <= hue_high_reg) &&
            (out_next.sat_pct >= sat_low_reg) && (out_next.sat_pct <= sat_high_reg) &&
            (out_next.int_pct > int_low_reg)  && (out_next.int_pct < int_high_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= chain_valid[NSTEP];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `RHSI_ASSERT_NOW(a_hue_range, aclk, aresetn, m_valid, m_data.hue_deg < 9'd360, "hue out of range")
    `RHSI_ASSERT_NOW(a_flat_hue, aclk, aresetn, m_valid && m_data.sat_pct == 7'd0, m_data.hue_deg == 9'd0, "hue set at zero saturation")
    `RHSI_ASSERT_NOW(a_stall_ready, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken during output stall")
    `RHSI_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready && chain_valid[NSTEP], chain_valid[NSTEP], "pipeline moved during stall")

endmodule
`default_nettype wire

FILE: verif/tb_rgb_hsi_red_pixel_classifier.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_hsi_red_pixel_classifier;
    import rhsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [2:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_IDX_SPARE_B = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    pixel_t      s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hsi_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;

    always #5 aclk = ~aclk;

    rgb_hsi_red_pixel_classifier u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    bit [22:0]  cos_q22 [0:90];
    bit [8:0]   win_hue_lo, win_hue_hi;
    bit [6:0]   win_sat_lo, win_sat_hi, win_int_lo, win_int_hi;
    hsi_t       hsi_pending[$];
    bit         typed_row;
    hsi_t       typed_word;
    int         fail_cnt = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;

    function automatic void build_cos_table();
        longint unsigned a, s, na, ns;
        a = 64'd1 << 30;
        s = 0;
        cos_q22[0] = 23'd4194304;
        for (int k = 1; k < 90; k++) begin
            na = (a * 64'd1073578288 - s * 64'd18739379 + (64'd1 << 29)) >> 30;
            ns = (s * 64'd1073578288 + a * 64'd18739379 + (64'd1 << 29)) >> 30;
            a = na;
            s = ns;
            cos_q22[k] = 23'((a + 64'd128) >> 8);
        end
        cos_q22[60] = 23'd2097152;
        cos_q22[90] = '0;
    endfunction

    // sign of n/(2*sqrt(d)) - cos(k deg)
    function automatic int cos_order(int n, longint unsigned d, int k);
        longint unsigned mag, an, lhs, rhs;
        int sc, sn, r;
        mag = cos_q22[k <= 90 ? k : 180 - k];
        sc = (mag == 0) ? 0 : (k > 90 ? -1 : 1);
        sn = (n > 0) ? 1 : (n < 0 ? -1 : 0);
        if (sn != sc) return (sn < sc) ? -1 : 1;
        if (sn == 0) return 0;
        an = (n < 0) ? -n : n;
        lhs = (an * an) << 44;
        rhs = 4 * mag * mag * d;
        r = (lhs < rhs) ? -1 : (lhs > rhs ? 1 : 0);
        return (sn > 0) ? r : -r;
    endfunction

    function automatic hsi_t classify_pixel(pixel_t p);
        int r, g, b, mn, mx, total, num, n, t;
        longint unsigned d;
        hsi_t h;
        r = p.red; g = p.green; b = p.blue;
        mn = (r < g) ? r : g;
        mx = (r > g) ? r : g;
        if (b < mn) mn = b;
        if (b > mx) mx = b;
        total = r + g + b;
        h = '0;
        h.int_pct = 7'((100 * total) / 765);
        if (mx != mn) begin
            num = total - 3 * mn;
            h.sat_pct = 7'((100 * num) / total);
            if (100 * num > total) begin
                n = 2 * r - g - b;
                d = longint'((r - g) * (r - g) + (r - b) * (g - b));
                t = 0;
                for (int k = 1; k <= 180; k++) begin
                    if (cos_order(n, d, k) <= 0) t = k;
                    else break;
                end
                if (b <= g) h.hue_deg = 9'(t);
                else if (cos_order(n, d, t) == 0) h.hue_deg = 9'(360 - t);
                else h.hue_deg = 9'(359 - t);
            end
        end
        h.is_target = h.hue_deg >= win_hue_lo && h.hue_deg <= win_hue_hi &&
                      h.sat_pct >= win_sat_lo && h.sat_pct <= win_sat_hi &&
                      h.int_pct > win_int_lo && h.int_pct < win_int_hi;
        return h;
    endfunction

    always @(posedge aclk) begin
        hsi_t want;
        if (!aresetn) begin
            win_hue_lo <= HUE_LOW_RST;  win_hue_hi <= HUE_HIGH_RST;
            win_sat_lo <= SAT_LOW_RST;  win_sat_hi <= SAT_HIGH_RST;
            win_int_lo <= INT_LOW_RST;  win_int_hi <= INT_HIGH_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HUE_LOW:  win_hue_lo <= cfg_data;
                    REG_HUE_HIGH: win_hue_hi <= cfg_data;
                    REG_SAT_LOW:  win_sat_lo <= cfg_data[6:0];
                    REG_SAT_HIGH: win_sat_hi <= cfg_data[6:0];
                    REG_INT_LOW:  win_int_lo <= cfg_data[6:0];
                    REG_INT_HIGH: win_int_hi <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                hsi_pending.push_back(typed_row ? typed_word : classify_pixel(s_data));
            if (m_valid && m_ready) begin
                if (hsi_pending.size() == 0) begin
                    $error("unexpected output word %h", m_data);
                    fail_cnt++;
                end else begin
                    want = hsi_pending.pop_front();
                    if (m_data.hue_deg !== want.hue_deg) begin
                        $error("hue_deg exp %0d got %0d", want.hue_deg, m_data.hue_deg);
                        fail_cnt++;
                    end
                    if (m_data.sat_pct !== want.sat_pct) begin
                        $error("sat_pct exp %0d got %0d", want.sat_pct, m_data.sat_pct);
                        fail_cnt++;
                    end
                    if (m_data.int_pct !== want.int_pct) begin
                        $error("int_pct exp %0d got %0d", want.int_pct, m_data.int_pct);
                        fail_cnt++;
                    end
                    if (m_data.is_target !== want.is_target) begin
                        $error("is_target exp %0d got %0d", want.is_target, m_data.is_target);
                        fail_cnt++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_hsi_red_pixel_classifier verification failed");
                $finish;
            end
        end
    end

    // output backpressure: switches between no stalls, random and periodic
    int stall_mode = 0;
    int stall_tick = 0;
    always @(negedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) > 3);
            default: m_ready <= ((stall_tick % 7) < 4);
        endcase
    end

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_window(int hl, int hh, int sl, int sh, int il, int ih);
        while (hsi_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_HUE_LOW, 9'(hl));
        write_reg(REG_HUE_HIGH, 9'(hh));
        write_reg(REG_SAT_LOW, 9'(sl));
        write_reg(REG_SAT_HIGH, 9'(sh));
        write_reg(REG_INT_LOW, 9'(il));
        write_reg(REG_INT_HIGH, 9'(ih));
    endtask

    task automatic send_pixel(pixel_t p, bit typed, hsi_t typed_val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        typed_row  <= typed;
        typed_word <= typed_val;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        int base;
        case ($urandom_range(0, 5))
            0: begin
                base = $urandom_range(0, 250);
                p = '{8'(base + $urandom_range(0, 5)), 8'(base + $urandom_range(0, 5)),
                      8'(base + $urandom_range(0, 5))};
            end
            1: p = '{8'($urandom_range(120, 255)), 8'($urandom_range(0, 90)),
                     8'($urandom_range(0, 120))};
            2: p = '{8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                     8'($urandom)};
            default: p = pixel_t'($urandom);
        endcase
        return p;
    endfunction

    typedef struct {
        pixel_t pix;
        bit     typed;
        hsi_t   want;
    } pixel_row_t;

    pixel_row_t directed_rows[] = '{
        '{'{8'd0, 8'd0, 8'd0},       1'b1, '{9'd0, 7'd0, 7'd0, 1'b0}},
        '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{9'd0, 7'd0, 7'd100, 1'b0}},
        '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{9'd0, 7'd0, 7'd50, 1'b0}},
        '{'{8'd255, 8'd0, 8'd0},     1'b0, '0},
        '{'{8'd0, 8'd255, 8'd0},     1'b0, '0},
        '{'{8'd0, 8'd0, 8'd255},     1'b0, '0},
        '{'{8'd255, 8'd255, 8'd0},   1'b0, '0},
        '{'{8'd0, 8'd255, 8'd255},   1'b0, '0},
        '{'{8'd255, 8'd0, 8'd255},   1'b0, '0},
        '{'{8'd1, 8'd0, 8'd0},       1'b0, '0},
        '{'{8'd0, 8'd0, 8'd1},       1'b0, '0},
        '{'{8'd100, 8'd100, 8'd101}, 1'b0, '0},
        '{'{8'd254, 8'd255, 8'd255}, 1'b0, '0},
        '{'{8'd200, 8'd30, 8'd60},   1'b0, '0},
        '{'{8'd170, 8'd85, 8'd85},   1'b0, '0},
        '{'{8'd255, 8'd0, 8'd128},   1'b0, '0},
        '{'{8'd128, 8'd0, 8'd255},   1'b0, '0},
        '{'{8'd0, 8'd128, 8'd255},   1'b0, '0},
        '{'{8'd85, 8'd170, 8'd170},  1'b0, '0},
        '{'{8'd255, 8'd1, 8'd0},     1'b0, '0}
    };

    initial begin
        build_cos_table();
        typed_row = 1'b0;
        typed_word = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
        for (int i = 0; i < 80; i++) send_pixel(random_pixel(), 1'b0, '0);
        s_valid <= 1'b0;
        burst_left = 0;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_window(0, 511, 0, 127, 0, 127);
                1: write_window(511, 0, 127, 0, 127, 0);
                2: write_window(0, 360, 0, 100, 0, 101);
                3: write_window($urandom_range(0, 359), $urandom_range(0, 511),
                                $urandom_range(0, 60), $urandom_range(40, 127),
                                $urandom_range(0, 50), $urandom_range(30, 127));
                default: begin
                    write_window(HUE_LOW_RST, HUE_HIGH_RST, SAT_LOW_RST, SAT_HIGH_RST,
                                 INT_LOW_RST, INT_HIGH_RST);
                    write_reg(CFG_IDX_SPARE_A, 9'h1FF);
                    write_reg(CFG_IDX_SPARE_B, 9'h000);
                end
            endcase
            for (int i = 0; i < 85; i++) send_pixel(random_pixel(), 1'b0, '0);
            s_valid <= 1'b0;
            burst_left = 0;
        end

        while (hsi_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0)
            $display("rgb_hsi_red_pixel_classifier verification clean");
        else
            $display("rgb_hsi_red_pixel_classifier verification failed");
        $finish;
    end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+design
design/rhsi_pkg.sv
design/rhsi_step.sv
design/rgb_hsi_red_pixel_classifier.sv
verif/tb_rgb_hsi_red_pixel_classifier.sv
